>>> sv/bspq_pkg.sv
// Shared widths, codes and control types of the bounded sorted priority queue.
`default_nettype none

package bspq_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned HDL_W  = 16;
  localparam int unsigned OPC_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_POP    = 2'd2
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_POP     = 3'd1,
    CELL_INS_POS = 3'd2,
    CELL_INS_TOK = 3'd3,
    CELL_SEEK    = 3'd4,
    CELL_STEP    = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic front_le;
    logic back_ge;
    logic found;
  } chain_sts_t;

endpackage

`default_nettype wire

>>> sv/bspq_ifs.sv
// Valid/ready channel interfaces: operation in, result out, capacity write.
`default_nettype none

interface bspq_in_if;
  import bspq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic signed [KEY_W-1:0] key;
  logic [HDL_W-1:0]        handle;

  modport source (output valid, output opcode, output key, output handle, input ready);
  modport sink   (input valid, input opcode, input key, input handle, output ready);
endinterface

interface bspq_out_if;
  import bspq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [HDL_W-1:0]        out_handle;
  logic signed [KEY_W-1:0] out_key;
  logic [CNT_W-1:0]        count;
  logic                    empty_res;

  modport source (output valid, output status, output out_handle, output out_key,
                  output count, output empty_res, input ready);
  modport sink   (input valid, input status, input out_handle, input out_key,
                  input count, input empty_res, output ready);
endinterface

interface bspq_cfg_if;
  import bspq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/bspq_cell.sv
// One storage cell of the queue row: key, handle and search token.
`default_nettype none

module bspq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned HB  = 16,
  parameter int unsigned CW  = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bspq_pkg::cell_ctl_t              ctl_i,
  input  logic [HB-1:0]                    new_hdl_i,
  input  logic [CW-1:0]                    pos_i,
  input  logic [CW-1:0]                    count_i,
  input  logic signed [bspq_pkg::KEY_W-1:0] left_key_i,
  input  logic [HB-1:0]                    left_hdl_i,
  input  logic signed [bspq_pkg::KEY_W-1:0] right_key_i,
  input  logic [HB-1:0]                    right_hdl_i,
  input  logic                             tok_i,
  output logic signed [bspq_pkg::KEY_W-1:0] key_o,
  output logic [HB-1:0]                    hdl_o,
  output logic                             tok_o,
  output logic                             le_o,
  output logic                             back_ge_o,
  output logic                             found_o
);
  import bspq_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic [HB-1:0]           hdl_q, hdl_d;
  logic                    tok_q, tok_d;
  logic                    passed_q, passed_d;
  logic                    keep, at_pos, is_last;

  assign le_o      = key_q <= ctl_i.key;
  assign is_last   = count_i == CW'(IDX + 1);
  assign back_ge_o = is_last & (key_q >= ctl_i.key);
  assign found_o   = tok_q & le_o;
  assign key_o     = key_q;
  assign hdl_o     = hdl_q;
  assign tok_o     = tok_q;

  always_comb begin
    key_d    = key_q;
    hdl_d    = hdl_q;
    tok_d    = tok_q;
    passed_d = passed_q;
    keep     = 1'b1;
    at_pos   = 1'b0;
    case (ctl_i.op)
      CELL_POP: begin
        key_d = right_key_i;
        hdl_d = right_hdl_i;
      end
      CELL_INS_POS: begin
        keep   = CW'(IDX) < pos_i;
        at_pos = CW'(IDX) == pos_i;
        tok_d  = 1'b0;
      end
      CELL_INS_TOK: begin
        keep   = passed_q;
        at_pos = tok_q;
        tok_d  = 1'b0;
      end
      CELL_SEEK: begin
        tok_d    = IDX == 1;
        passed_d = IDX == 0;
      end
      CELL_STEP: begin
        tok_d    = tok_i;
        passed_d = passed_q | tok_q;
      end
      default: ;
    endcase
    // insert: cells past the slot take their left neighbour's word
    if ((ctl_i.op == CELL_INS_POS || ctl_i.op == CELL_INS_TOK) && !keep) begin
      if (at_pos) begin
        key_d = ctl_i.key;
        hdl_d = new_hdl_i;
      end else begin
        key_d = left_key_i;
        hdl_d = left_hdl_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    hdl_q <= hdl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      tok_q    <= tok_d;
      passed_q <= passed_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/bspq_chain.sv
// Row of queue cells, front at cell 0, with the status reductions.
`default_nettype none

module bspq_chain #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned HB    = 16,
  parameter int unsigned CW    = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bspq_pkg::cell_ctl_t              ctl_i,
  input  logic [HB-1:0]                    new_hdl_i,
  input  logic [CW-1:0]                    pos_i,
  input  logic [CW-1:0]                    count_i,
  output logic signed [bspq_pkg::KEY_W-1:0] head_key_o,
  output logic [HB-1:0]                    head_hdl_o,
  output bspq_pkg::chain_sts_t             sts_o
);
  import bspq_pkg::*;

  logic signed [KEY_W-1:0] key_w [DEPTH];
  logic [HB-1:0]           hdl_w [DEPTH];
  logic [DEPTH-1:0]        tok_w, le_w, back_w, found_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] lkey, rkey;
    logic [HB-1:0]           lhdl, rhdl;
    logic                    ltok;

    if (i == 0) begin : g_first
      assign lkey = '0;
      assign lhdl = '0;
      assign ltok = 1'b0;
    end else begin : g_mid
      assign lkey = key_w[i-1];
      assign lhdl = hdl_w[i-1];
      assign ltok = tok_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey = '0;
      assign rhdl = '0;
    end else begin : g_inner
      assign rkey = key_w[i+1];
      assign rhdl = hdl_w[i+1];
    end

    bspq_cell #(
      .IDX (i),
      .HB  (HB),
      .CW  (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .new_hdl_i   (new_hdl_i),
      .pos_i       (pos_i),
      .count_i     (count_i),
      .left_key_i  (lkey),
      .left_hdl_i  (lhdl),
      .right_key_i (rkey),
      .right_hdl_i (rhdl),
      .tok_i       (ltok),
      .key_o       (key_w[i]),
      .hdl_o       (hdl_w[i]),
      .tok_o       (tok_w[i]),
      .le_o        (le_w[i]),
      .back_ge_o   (back_w[i]),
      .found_o     (found_w[i])
    );
  end

  assign head_key_o     = key_w[0];
  assign head_hdl_o     = hdl_w[0];
  assign sts_o.front_le = le_w[0];
  assign sts_o.back_ge  = |back_w;
  assign sts_o.found    = |found_w;

  // search token: at most one cell holds it
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w)) else $error("search token held by more than one cell");

  a_seek_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == CELL_SEEK |=> tok_w[1]) else $error("search did not start at cell 1");

  a_step_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op == CELL_STEP |=> tok_w == ($past(tok_w) << 1))
    else $error("search token did not advance by one cell");

endmodule

`default_nettype wire

>>> sv/bounded_sorted_priority_queue.sv
// Top level of the bounded sorted priority queue: control, capacity and result register.
`default_nettype none

// Bounded priority queue held as a row of DEPTH cells, front (largest key) in
// cell 0, each cell holding one (key, handle) word. An operation word carries
// opcode, key and handle; every accepted word returns exactly one result word
// with status, popped entry (zero unless a pop succeeded), the count after the
// operation and an empty flag. Pop, append, insert into an empty list and a
// sorted insert that lands at the front or the back all shift the row in one
// go: the word is latched on acceptance, the row shifts and the result
// register is loaded in the execute state, and only then is the next word
// taken. A sorted insert that lands in the middle walks a search token down
// the row one cell per clock from cell 1 until it finds the slot it lands in
// (at most count - 1); the result is loaded there and only then is the next
// word taken. A new word is taken while an earlier result still waits in the
// output register; its own result then waits for that register to be freed.
// Capacity (reset 64, clipped to DEPTH) is written
// on the configuration channel, which never stalls; write it only when the
// queue is quiet. Inserts at or above capacity are dropped with status full,
// a pop on an empty queue reports status empty, and an unknown opcode returns
// status done with no change. Keys compare as signed Q16.16; handles are kept
// at HANDLE_BITS bits.

module bounded_sorted_priority_queue #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bspq_in_if.sink           in_i,
  bspq_out_if.source        out_o,
  bspq_cfg_if.sink          cfg_i
);
  import bspq_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // latched operation word
  logic [OPC_W-1:0]        op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [HANDLE_BITS-1:0]  hdl_q;

  logic [CW-1:0]    count_q, count_d;
  logic [CAP_W-1:0] cap_q;

  // result register
  logic                    res_valid_q, res_valid_d;
  logic [STAT_W-1:0]       res_stat_q, res_stat_d;
  logic [HDL_W-1:0]        res_hdl_q, res_hdl_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;
  logic [CNT_W-1:0]        res_cnt_q, res_cnt_d;
  logic                    res_empty_q, res_empty_d;

  cell_ctl_t               ctl;
  chain_sts_t              sts;
  logic [CW-1:0]           pos;
  logic signed [KEY_W-1:0] head_key;
  logic [HANDLE_BITS-1:0]  head_hdl;

  logic            in_acc, fin_ok, done, full;
  logic [CMPW-1:0] cap_w, cap_eff;

  assign in_acc = in_i.valid & in_i.ready;
  // result register free this cycle
  assign fin_ok = !res_valid_q || out_o.ready;

  assign cap_w   = CMPW'(cap_q);
  assign cap_eff = (cap_w > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_w;
  assign full    = CMPW'(count_q) >= cap_eff;

  bspq_chain #(
    .DEPTH (DEPTH),
    .HB    (HANDLE_BITS),
    .CW    (CW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .new_hdl_i  (hdl_q),
    .pos_i      (pos),
    .count_i    (count_q),
    .head_key_o (head_key),
    .head_hdl_o (head_hdl),
    .sts_o      (sts)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ctl.op     = CELL_HOLD;
    ctl.key    = key_q;
    pos        = count_q;
    done       = 1'b0;
    res_stat_d = STAT_DONE;
    res_hdl_d  = '0;
    res_key_d  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fin_ok) begin
          done = 1'b1;
          case (op_q)
            OP_INSERT, OP_APPEND: begin
              if (full) begin
                res_stat_d = STAT_FULL;
              end else if (op_q == OP_APPEND || count_q == '0) begin
                ctl.op  = CELL_INS_POS;
                count_d = count_q + CW'(1);
              end else if (sts.front_le) begin
                ctl.op  = CELL_INS_POS;
                pos     = '0;
                count_d = count_q + CW'(1);
              end else if (sts.back_ge) begin
                ctl.op  = CELL_INS_POS;
                count_d = count_q + CW'(1);
              end else begin
                // middle slot: start the token walk at cell 1
                ctl.op  = CELL_SEEK;
                done    = 1'b0;
                state_d = ST_SCAN;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_stat_d = STAT_EMPTY;
              end else begin
                ctl.op    = CELL_POP;
                res_hdl_d = HDL_W'(head_hdl);
                res_key_d = head_key;
                count_d   = count_q - CW'(1);
              end
            end
            default: ;
          endcase
          if (done) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (sts.found) begin
          if (fin_ok) begin
            ctl.op  = CELL_INS_TOK;
            count_d = count_q + CW'(1);
            done    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          ctl.op = CELL_STEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_cnt_d   = CNT_W'(count_d);
  assign res_empty_d = count_d == '0;
  assign res_valid_d = done | (res_valid_q & !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.opcode;
      key_q <= in_i.key;
      hdl_q <= HANDLE_BITS'(in_i.handle);
    end
    if (done) begin
      res_stat_q  <= res_stat_d;
      res_hdl_q   <= res_hdl_d;
      res_key_q   <= res_key_d;
      res_cnt_q   <= res_cnt_d;
      res_empty_q <= res_empty_d;
    end
  end

  assign in_i.ready       = state_q == ST_IDLE;
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = res_valid_q;
  assign out_o.status     = res_stat_q;
  assign out_o.out_handle = res_hdl_q;
  assign out_o.out_key    = res_key_q;
  assign out_o.count      = res_cnt_q;
  assign out_o.empty_res  = res_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(DEPTH)) else $error("entry count beyond depth");

  a_scan_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> count_q >= CW'(2)) else $error("middle search with under two entries");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.op == CELL_POP |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not lower the count by one");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> res_valid_q && state_q == ST_IDLE) else $error("finished word not presented");

endmodule

`default_nettype wire
